// ===== rtl/assert_macros.svh =====
// shared assertion forms for the median filter checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define MF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("median filter check failed");

// condition holds in the cycle after the trigger
`define MF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("median filter check failed");

// condition holds in the cycle after reset is seen
`define MF_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("median filter reset check failed");

`endif

// ===== rtl/mf3_pkg.sv =====
package mf3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int PIX_W      = 8;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 16;
   localparam int PEND_W     = $clog2(MAX_WIDTH + 2);
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef logic [PIX_W-1:0] pixel_type;
   // index r*3+k: row r (0 = top), column k (2 = newest)
   typedef pixel_type [8:0] window_type;

endpackage

// ===== rtl/mf3_median9.sv =====
module mf3_median9 (
   input  mf3_pkg::window_type window,
   output mf3_pkg::pixel_type  median
);

   function automatic logic [2*mf3_pkg::PIX_W-1:0] order2(
      input mf3_pkg::pixel_type a,
      input mf3_pkg::pixel_type b
   );
      logic [2*mf3_pkg::PIX_W-1:0] res;
      res = (a > b) ? {b, a} : {a, b};
      return res;
   endfunction

   mf3_pkg::pixel_type v [9];

   // 19 compare-exchange network, fifth smallest lands in v[4]
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         v[i] = window[i];
      end
      {v[1], v[2]} = order2(v[1], v[2]);
      {v[4], v[5]} = order2(v[4], v[5]);
      {v[7], v[8]} = order2(v[7], v[8]);
      {v[0], v[1]} = order2(v[0], v[1]);
      {v[3], v[4]} = order2(v[3], v[4]);
      {v[6], v[7]} = order2(v[6], v[7]);
      {v[1], v[2]} = order2(v[1], v[2]);
      {v[4], v[5]} = order2(v[4], v[5]);
      {v[7], v[8]} = order2(v[7], v[8]);
      {v[0], v[3]} = order2(v[0], v[3]);
      {v[5], v[8]} = order2(v[5], v[8]);
      {v[4], v[7]} = order2(v[4], v[7]);
      {v[3], v[6]} = order2(v[3], v[6]);
      {v[1], v[4]} = order2(v[1], v[4]);
      {v[2], v[5]} = order2(v[2], v[5]);
      {v[4], v[7]} = order2(v[4], v[7]);
      {v[4], v[2]} = order2(v[4], v[2]);
      {v[6], v[4]} = order2(v[6], v[4]);
      {v[4], v[2]} = order2(v[4], v[2]);
   end

   assign median = v[4];

endmodule

// ===== rtl/median_filter_3x3_core.sv =====
// 3x3 median filter for 8-bit grayscale frames in raster order.
// Request channel (req_valid / req_stall): one item per pixel, req_command
// selects a pixel (req_pixel_in used) or a flush that drains one output of
// the frame tail. Response channel (rsp_valid / rsp_stall): filtered pixels
// in raster order, rsp_frame_last on the final pixel of each frame. Border
// rows and columns are passed through unfiltered.
// Frame size is set through the csr port (index 0 width, 1 height) while
// the block is idle; both line stores are single-port-write block memories
// of MAX_WIDTH pixels, so no clearing pass is needed after reset.
// Throughput: one item per clock while req_stall is low. An item that
// produces an output goes through the line store read into stage 1, then
// the median network into the output register. Outputs trail the input
// stream by frame_width+1 pixels; flush items drain the last frame's tail.
// Reset clears the counters, the window and the output register and
// restores width 640 and height 480; req_stall is high during reset.
// When the receiver stalls, the output holds; req_stall then rises only
// if the item waiting behind the output register would also produce one.
module median_filter_3x3_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [mf3_pkg::PIX_W-1:0]           req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mf3_pkg::PIX_W-1:0]           rsp_pixel_out,
   output logic                                rsp_frame_last
);

   localparam int COL_W    = mf3_pkg::COL_W;
   localparam int WIDTH_W  = mf3_pkg::WIDTH_W;
   localparam int HEIGHT_W = mf3_pkg::HEIGHT_W;
   localparam int PEND_W   = mf3_pkg::PEND_W;

   typedef struct packed {
      logic flush;
      logic emit;
      logic border;
      logic last;
      logic from_mid;
   } s1_ctrl_type;

   // configuration
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [WIDTH_W-1:0]  eff_w;
   logic [WIDTH_W-1:0]  w_m1;
   logic [WIDTH_W-1:0]  full;
   logic [HEIGHT_W-1:0] eff_h;
   logic [HEIGHT_W-1:0] h_m1;

   // position counters
   logic [COL_W-1:0]    in_col_ff,  in_col_in;
   logic [HEIGHT_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [PEND_W-1:0]   pend_ff,    pend_in;

   // line stores
   mf3_pkg::pixel_type  upper_store_ff  [mf3_pkg::MAX_WIDTH];
   mf3_pkg::pixel_type  middle_store_ff [mf3_pkg::MAX_WIDTH];
   logic [COL_W-1:0]    mid_addr;

   // stage 1
   logic                s1_valid_ff;
   s1_ctrl_type         s1_ctrl_ff, s1_ctrl_in;
   mf3_pkg::pixel_type  s1_px_ff;
   logic [COL_W-1:0]    s1_addr_ff;
   mf3_pkg::pixel_type  rd_top_ff;
   mf3_pkg::pixel_type  rd_mid_ff;

   // window and output
   mf3_pkg::window_type window_ff, window_in;
   mf3_pkg::pixel_type  median;
   mf3_pkg::pixel_type  out_pixel_in;
   logic                rsp_valid_ff;
   mf3_pkg::pixel_type  rsp_pixel_ff;
   logic                rsp_last_ff;

   // accept-time control
   logic                req_accept;
   logic                is_flush;
   logic                at_start;
   logic                restart;
   logic [COL_W-1:0]    oc_base;
   logic [HEIGHT_W-1:0] or_base;
   logic [PEND_W-1:0]   pend_base;
   logic [PEND_W:0]     pend_inc;
   logic                px_emit;
   logic                fl_emit;
   logic                out_col_end;
   logic                out_row_end;
   logic [COL_W-1:0]    oc_next;
   logic [HEIGHT_W-1:0] or_next;
   logic                in_col_end;
   logic                in_row_end;
   logic                out_free;
   logic                s1_move;

   always_comb begin
      if (width_ff < WIDTH_W'(3)) begin
         eff_w = WIDTH_W'(3);
      end else if (width_ff > WIDTH_W'(mf3_pkg::MAX_WIDTH)) begin
         eff_w = WIDTH_W'(mf3_pkg::MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      eff_h = (height_ff < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_ff;
      w_m1  = eff_w - WIDTH_W'(1);
      h_m1  = eff_h - HEIGHT_W'(1);
      full  = eff_w + WIDTH_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::WIDTH_RESET;
         height_ff <= mf3_pkg::HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mf3_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_write_data[WIDTH_W-1:0];
            mf3_pkg::REG_FRAME_HEIGHT: height_ff <= csr_write_data[HEIGHT_W-1:0];
         endcase
      end
   end

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && (out_free || !s1_ctrl_ff.emit);
   assign req_stall  = reset || (s1_valid_ff && !s1_move);
   assign req_accept = req_valid && !req_stall;
   assign is_flush   = (req_command == mf3_pkg::CMD_FLUSH);

   always_comb begin
      at_start  = (in_col_ff == '0) && (in_row_ff == '0);
      // a pixel at frame start drops a partly drained tail; a full one is pushed out
      restart   = !is_flush && at_start && (pend_ff != full);
      oc_base   = restart ? '0 : out_col_ff;
      or_base   = restart ? '0 : out_row_ff;
      pend_base = restart ? '0 : pend_ff;
      pend_inc  = {1'b0, pend_base} + (PEND_W+1)'(1);
      px_emit   = pend_inc > {1'b0, full};
      fl_emit   = at_start && (pend_ff != '0);

      out_col_end = {1'b0, oc_base} >= w_m1;
      out_row_end = or_base >= h_m1;
      if (out_col_end) begin
         oc_next = '0;
         or_next = out_row_end ? '0 : HEIGHT_W'(or_base + HEIGHT_W'(1));
      end else begin
         oc_next = COL_W'(oc_base + COL_W'(1));
         or_next = or_base;
      end

      in_col_end = {1'b0, in_col_ff} >= w_m1;
      in_row_end = in_row_ff >= h_m1;

      s1_ctrl_in.flush    = is_flush;
      s1_ctrl_in.emit     = is_flush ? fl_emit : px_emit;
      s1_ctrl_in.border   = (or_base == '0) || out_row_end || (oc_base == '0) || out_col_end;
      s1_ctrl_in.last     = out_row_end && out_col_end;
      s1_ctrl_in.from_mid = out_row_end;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in    = pend_ff;
      if (is_flush) begin
         if (fl_emit) begin
            out_col_in = oc_next;
            out_row_in = or_next;
            pend_in    = pend_ff - PEND_W'(1);
         end
      end else begin
         if (in_col_end) begin
            in_col_in = '0;
            in_row_in = in_row_end ? '0 : HEIGHT_W'(in_row_ff + HEIGHT_W'(1));
         end else begin
            in_col_in = COL_W'(in_col_ff + COL_W'(1));
         end
         out_col_in = px_emit ? oc_next : oc_base;
         out_row_in = px_emit ? or_next : or_base;
         pend_in    = px_emit ? full : pend_inc[PEND_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
      end else if (req_accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
      end
   end

   // flush reads the middle store at the output column
   assign mid_addr = is_flush ? out_col_ff : in_col_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_top_ff <= upper_store_ff[in_col_ff];
         rd_mid_ff <= middle_store_ff[mid_addr];
         if (!is_flush) begin
            middle_store_ff[in_col_ff] <= req_pixel_in;
         end
      end
      // upper row takes the old middle value once it has been read
      if (s1_move && !s1_ctrl_ff.flush) begin
         upper_store_ff[s1_addr_ff] <= rd_mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_px_ff   <= req_pixel_in;
         s1_addr_ff <= in_col_ff;
      end
   end

   always_comb begin
      window_in    = window_ff;
      window_in[0] = window_ff[1];
      window_in[1] = window_ff[2];
      window_in[2] = rd_top_ff;
      window_in[3] = window_ff[4];
      window_in[4] = window_ff[5];
      window_in[5] = rd_mid_ff;
      window_in[6] = window_ff[7];
      window_in[7] = window_ff[8];
      window_in[8] = s1_px_ff;
   end

   mf3_median9 u_median9 (
      .window (window_in),
      .median (median)
   );

   always_comb begin
      if (s1_ctrl_ff.flush) begin
         out_pixel_in = s1_ctrl_ff.from_mid ? rd_mid_ff : window_ff[5];
      end else begin
         out_pixel_in = s1_ctrl_ff.border ? window_in[4] : median;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_move && !s1_ctrl_ff.flush) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move && s1_ctrl_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_ctrl_ff.emit) begin
         rsp_pixel_ff <= out_pixel_in;
         rsp_last_ff  <= s1_ctrl_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// ===== rtl/mf3_checker.sv =====
`include "assert_macros.svh"

module mf3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [mf3_pkg::PIX_W-1:0]      rsp_pixel_out,
   input logic                           rsp_frame_last
);

   // a held output keeps its item
   `MF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `MF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
                   $stable(rsp_pixel_out) && $stable(rsp_frame_last))

   // output register is empty right after reset
   `MF_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_valid)

   // input backs up only behind a stalled output
   `MF_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a fresh output comes from an accepted item that has passed through stage 1
   `MF_ASSERT_NOW(a_latency, clock, reset, $rose(rsp_valid),
                  $past(req_valid && !req_stall, 2))

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int unsigned CYCLE_LIMIT    = 400_000;
   localparam int unsigned RANDOM_ITEMS   = 1440;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned PRESSURE_AT    = 150;
   localparam int unsigned PRESSURE_HOLD  = 400;
   localparam int unsigned MISMATCH_SHOWN = 10;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} check_kind_type;

   typedef struct packed {
      mf3_pkg::pixel_type pixel;
      logic               last;
   } filtered_px_type;

   typedef struct packed {
      logic               cmd;
      mf3_pkg::pixel_type px;
      check_kind_type     kind;
      mf3_pkg::pixel_type pixel;
      logic               last;
   } directed_row_type;

   // 3x3 frame: rows 10 200 30 / 40 255 60 / 70 0 90, then a checkerboard frame
   localparam directed_row_type DIRECTED [0:24] = '{
      '{mf3_pkg::CMD_FLUSH, 8'd0,   CHK_NONE,  8'd0,   1'b0},  // nothing pending after reset
      '{mf3_pkg::CMD_PIXEL, 8'd10,  CHK_NONE,  8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd200, CHK_NONE,  8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd30,  CHK_NONE,  8'd0,   1'b0},
      '{mf3_pkg::CMD_FLUSH, 8'd0,   CHK_NONE,  8'd0,   1'b0},  // mid-frame flush is ignored
      '{mf3_pkg::CMD_PIXEL, 8'd40,  CHK_NONE,  8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd255, CHK_VALUE, 8'd10,  1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd60,  CHK_VALUE, 8'd200, 1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd70,  CHK_VALUE, 8'd30,  1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd0,   CHK_VALUE, 8'd40,  1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd90,  CHK_VALUE, 8'd60,  1'b0},  // centre: median of all nine
      '{mf3_pkg::CMD_FLUSH, 8'd0,   CHK_VALUE, 8'd60,  1'b0},
      '{mf3_pkg::CMD_FLUSH, 8'd0,   CHK_VALUE, 8'd70,  1'b0},
      '{mf3_pkg::CMD_FLUSH, 8'd0,   CHK_VALUE, 8'd0,   1'b0},
      '{mf3_pkg::CMD_FLUSH, 8'd0,   CHK_VALUE, 8'd90,  1'b1},
      '{mf3_pkg::CMD_FLUSH, 8'd0,   CHK_NONE,  8'd0,   1'b0},  // tail already drained
      '{mf3_pkg::CMD_PIXEL, 8'd255, CHK_MODEL, 8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd255, CHK_MODEL, 8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd255, CHK_MODEL, 8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd255, CHK_MODEL, 8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
      '{mf3_pkg::CMD_PIXEL, 8'd255, CHK_MODEL, 8'd0,   1'b0}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [mf3_pkg::CSR_IDX_W-1:0]  csr_index = mf3_pkg::REG_FRAME_WIDTH;
   logic [mf3_pkg::CSR_DATA_W-1:0] csr_write_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_command = mf3_pkg::CMD_PIXEL;
   logic [mf3_pkg::PIX_W-1:0]      req_pixel_in = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [mf3_pkg::PIX_W-1:0]      rsp_pixel_out;
   logic                           rsp_frame_last;

   median_filter_3x3_core uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_frame_last   (rsp_frame_last)
   );

   always #10 clock = ~clock;

   // filter state mirror
   bit [mf3_pkg::PIX_W-1:0]      upper_row [mf3_pkg::MAX_WIDTH];
   bit [mf3_pkg::PIX_W-1:0]      middle_row [mf3_pkg::MAX_WIDTH];
   mf3_pkg::window_type          win = '0;
   int unsigned                  in_col, in_row, out_col, out_row, pend_cnt;
   logic [mf3_pkg::WIDTH_W-1:0]  width_reg = mf3_pkg::WIDTH_RESET;
   logic [mf3_pkg::HEIGHT_W-1:0] height_reg = mf3_pkg::HEIGHT_RESET;

   filtered_px_type filtered_q [$];
   int unsigned  outstanding, errors, results_seen, useful_items, frames_done, csr_writes;
   int unsigned  cycle_count;
   bit           offering, sender_burst, rx_burst, fast_mode;

   function automatic int unsigned active_width();
      int unsigned w;
      w = 32'(width_reg);
      if (w < 3) w = 3;
      if (w > mf3_pkg::MAX_WIDTH) w = mf3_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned active_height();
      return (height_reg < 16'd3) ? 32'd3 : 32'(height_reg);
   endfunction

   function automatic mf3_pkg::pixel_type median_of(mf3_pkg::window_type v);
      int below, upto;
      for (int i = 0; i < 9; i++) begin
         below = 0;
         upto = 0;
         for (int j = 0; j < 9; j++) begin
            if (v[j] < v[i]) below++;
            if (v[j] <= v[i]) upto++;
         end
         if (below <= 4 && upto >= 5) return v[i];
      end
      return v[4];
   endfunction

   function automatic filtered_px_type take_output(mf3_pkg::pixel_type v, int unsigned w,
                                                   int unsigned h);
      filtered_px_type r;
      r.pixel = v;
      r.last = (out_row >= h - 1) && (out_col >= w - 1);
      if (out_col + 1 >= w) begin
         out_col = 0;
         out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
      end else begin
         out_col++;
      end
      return r;
   endfunction

   function automatic bit filter_accept(input logic cmd, input mf3_pkg::pixel_type px,
                                        output filtered_px_type res);
      int unsigned        w, h, full;
      bit                 at_start, border;
      mf3_pkg::pixel_type top, mid, v;
      w = active_width();
      h = active_height();
      full = w + 1;
      at_start = (in_col == 0) && (in_row == 0);
      res = '0;
      if (cmd == mf3_pkg::CMD_FLUSH) begin
         if (!at_start || pend_cnt == 0) return 1'b0;
         v = (out_row >= h - 1) ? mf3_pkg::pixel_type'(middle_row[out_col]) : win[5];
         res = take_output(v, w, h);
         pend_cnt--;
         return 1'b1;
      end
      top = upper_row[in_col];
      mid = middle_row[in_col];
      // a new frame drops a partly drained tail; a full one is pushed out by it
      if (at_start && pend_cnt != full) begin
         pend_cnt = 0;
         out_col = 0;
         out_row = 0;
      end
      for (int r = 0; r < 3; r++) begin
         win[r*3] = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      upper_row[in_col] = mid;
      middle_row[in_col] = px;
      if (in_col + 1 >= w) begin
         in_col = 0;
         in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
      end else begin
         in_col++;
      end
      pend_cnt++;
      if (pend_cnt > full) begin
         border = out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1;
         v = border ? win[4] : median_of(win);
         pend_cnt = full;
         res = take_output(v, w, h);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int unsigned next_gap();
      return (fast_mode || sender_burst) ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic void flag_mismatch(string what);
      errors++;
      if (errors <= MISMATCH_SHOWN) $display("mismatch: %s", what);
   endfunction

   task automatic send_item(logic cmd, mf3_pkg::pixel_type px, int unsigned gap,
                            check_kind_type kind, filtered_px_type typed);
      filtered_px_type res;
      bit              emitted, taken;
      if (gap > 0) begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_pixel_in <= px;
      offering = 1'b1;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      emitted = filter_accept(cmd, px, res);
      if (cmd == mf3_pkg::CMD_PIXEL || emitted) useful_items++;
      if (kind == CHK_VALUE) begin
         filtered_q.push_back(typed);
         outstanding++;
      end else if (kind == CHK_MODEL && emitted) begin
         filtered_q.push_back(res);
         outstanding++;
      end
   endtask

   // flush out the frame tail, then wait until the block has gone quiet
   task automatic drain_and_settle();
      while (pend_cnt > 0)
         send_item(mf3_pkg::CMD_FLUSH, 8'($urandom), next_gap(), CHK_MODEL, '0);
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      wait (outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(bit wr_w, logic [mf3_pkg::CSR_DATA_W-1:0] w_data,
                            bit wr_h, logic [mf3_pkg::CSR_DATA_W-1:0] h_data);
      drain_and_settle();
      if (wr_w) begin
         csr_write_enable <= 1'b1;
         csr_index <= mf3_pkg::REG_FRAME_WIDTH;
         csr_write_data <= w_data;
         width_reg = w_data[mf3_pkg::WIDTH_W-1:0];
         csr_writes++;
         @(posedge clock);
      end
      if (wr_h) begin
         csr_write_enable <= 1'b1;
         csr_index <= mf3_pkg::REG_FRAME_HEIGHT;
         csr_write_data <= h_data;
         height_reg = h_data[mf3_pkg::HEIGHT_W-1:0];
         csr_writes++;
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_frame();
      int unsigned        n, style, r;
      bit                 noisy;
      mf3_pkg::pixel_type px;
      n = active_width() * active_height();
      style = $urandom_range(0, 2);
      noisy = !fast_mode && ($urandom_range(0, 3) == 0);
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_item(mf3_pkg::CMD_FLUSH, 8'($urandom), next_gap(), CHK_MODEL, '0);
         case (style)
            0: px = 8'($urandom);
            1: begin
               // salt and pepper around a mid-gray level
               r = $urandom_range(0, 9);
               px = (r < 3) ? 8'h00 : (r < 6) ? 8'hFF : 8'($urandom_range(100, 140));
            end
            default: px = 8'(i * 3) ^ 8'($urandom_range(0, 7));
         endcase
         send_item(mf3_pkg::CMD_PIXEL, px, next_gap(), CHK_MODEL, '0);
      end
      frames_done++;
   endtask

   initial begin
      int unsigned     w_pick, h_pick, sel;
      filtered_px_type typed;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // out-of-range sizes clamp to 3x3
      set_frame(1'b1, 16'd1, 1'b1, 16'd0);
      foreach (DIRECTED[i]) begin
         typed.pixel = DIRECTED[i].pixel;
         typed.last = DIRECTED[i].last;
         send_item(DIRECTED[i].cmd, DIRECTED[i].px, next_gap(), DIRECTED[i].kind, typed);
      end
      while (useful_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            w_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            sel = $urandom_range(0, 2);
            set_frame(sel != 2, {5'($urandom), 11'(w_pick)}, sel != 1, 16'(h_pick));
         end
         run_frame();
         case ($urandom_range(0, 3))
            0, 1: ;  // next frame pushes the tail out
            2: repeat ($urandom_range(1, active_width()))
                  send_item(mf3_pkg::CMD_FLUSH, 8'($urandom), next_gap(), CHK_MODEL, '0);
            default: repeat (active_width() + 1 + $urandom_range(0, 2))
                  send_item(mf3_pkg::CMD_FLUSH, 8'($urandom), next_gap(), CHK_MODEL, '0);
         endcase
      end
      // one last frame streamed at full rate
      fast_mode = 1'b1;
      set_frame(1'b1, 16'd12, 1'b1, 16'd8);
      run_frame();
      drain_and_settle();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d items over %0d frames with %0d register writes, %0d outputs checked",
               useful_items, frames_done, csr_writes, results_seen);
      $display("frame sizes from clamped 3x3 up to 12x8, a long receiver hold-off, %0d mismatches",
               errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      filtered_px_type    want;
      int unsigned        hold;
      bit                 seen;
      mf3_pkg::pixel_type got_px;
      logic               got_last;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (fast_mode) begin
            hold = 0;
         end else if (results_seen == PRESSURE_AT) begin
            // long hold-off so the pipeline backs up into req_stall
            hold = PRESSURE_HOLD;
         end else begin
            if (results_seen % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            hold = rx_burst ? 0 : $urandom_range(0, 19);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do begin
            @(negedge clock);
            seen = rsp_valid && !rsp_stall;
            got_px = rsp_pixel_out;
            got_last = rsp_frame_last;
            @(posedge clock);
         end while (!seen);
         results_seen++;
         if (filtered_q.size() == 0) begin
            flag_mismatch($sformatf("output %0d (pixel %0d last %0b) with nothing expected",
                                    results_seen, got_px, got_last));
         end else begin
            want = filtered_q.pop_front();
            outstanding--;
            if (got_px !== want.pixel || got_last !== want.last)
               flag_mismatch($sformatf("output %0d: expected pixel %0d last %0b, got %0d %0b",
                                       results_seen, want.pixel, want.last, got_px, got_last));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed out with %0d outputs still expected", outstanding);
      $display("FAILURE");
      $finish;
   end

endmodule
